FILE: rtl/hll_pkg.sv
// hll_pkg: shared constants, payload structs and register codes for the
// hyperloglog sketch core. No dependencies.
package hll_pkg;

  localparam int MAX_INDEX_BITS = 12;
  localparam int DEPTH          = 1 << MAX_INDEX_BITS;
  localparam int IDX_W          = MAX_INDEX_BITS;
  localparam int RANK_W         = 5;
  localparam int PREC_W         = 4;
  localparam int ALPHA_W        = 16;
  localparam int HASH_W         = 32;
  localparam int EST_W          = 56;
  localparam int ZERO_W         = 13;
  localparam int SUM_W          = 33 + IDX_W;
  localparam int NUM_W          = 64;
  localparam int CNT_W          = IDX_W + 1;
  localparam int PREC_MIN       = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;

  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_ESTIMATE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [HASH_W-1:0] hash_value;
  } hll_in_t;

  typedef struct packed {
    logic [EST_W-1:0]  raw_estimate;
    logic [ZERO_W-1:0] zero_registers;
  } hll_out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } hll_div_req_t;

endpackage

FILE: rtl/hll_ram.sv
// hll_ram: generic simple dual-port ram, one write and one registered read
// port, read-first on a same-address collision. No dependencies.
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hll_div.sv
// hll_div: restoring long divider, one quotient bit per cycle, with the
// quotient saturated to the estimate width. Depends on hll_pkg.
module hll_div
  import hll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hll_div_req_t     req_i,
  output logic             done_o,
  output logic [EST_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, req_i.den};
  assign ge     = rem_sh >= {1'b0, req_i.den};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d = req_i.num;
      quo_d = '0;
      rem_d = '0;
      cnt_d = STEP_W'(NUM_W);
    end else if (cnt_q != '0) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == STEP_W'(1));
    end
  end

  // divisor is held stable by the caller for the whole run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = (quo_q[NUM_W-1:EST_W] != '0) ? {EST_W{1'b1}} : quo_q[EST_W-1:0];

endmodule

FILE: rtl/hyperloglog_cardinality_sketch_core.sv
// hyperloglog_cardinality_sketch_core: top level of the sketch, rank store,
// add pipeline, estimate sweep and result register.
// Depends on hll_pkg, hll_ram and hll_div.
//
// After reset the core clears its 4096-entry rank store, one entry a cycle,
// and takes no item until the clear is done (configuration writes are
// taken throughout). Adds then go one per cycle while the core is idle: each
// is a read-modify-write of the rank store through its registered read port,
// with the just-written entry forwarded to the next add. An estimate request
// walks the 2^p ranks in use, one store read a cycle, then runs a 64-step
// bit-serial divider; its one result beat is registered once the output
// register is free, and the core takes the next item from the cycle that beat
// is first shown at the earliest. Adds produce no result. Configuration
// registers may be rewritten only while the core is idle; changing precision
// does not clear the store.
module hyperloglog_cardinality_sketch_core
  import hll_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hll_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hll_out_t              out_data_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PREC_W-1:0]  prec_q, prec_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rv_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [ZERO_W-1:0]  zeros_q, zeros_d;
  logic               s1_valid_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [RANK_W-1:0]  s1_rank_q;
  logic               fwd_valid_q;
  logic [IDX_W-1:0]   fwd_idx_q;
  logic [RANK_W-1:0]  fwd_val_q;
  logic               out_valid_q, out_valid_d;
  hll_out_t           out_data_q, out_data_d;

  logic [PREC_W-1:0]  p_eff;
  logic [CNT_W-1:0]   m_regs;
  logic               in_acc;
  logic               add_acc;
  logic               est_acc;
  logic [IDX_W-1:0]   add_idx;
  logic [RANK_W-1:0]  add_rank;
  logic [HASH_W-1:0]  rank_word;
  logic               issuing;
  logic               sweep_done;
  logic [RANK_W-1:0]  rdata;
  logic [RANK_W-1:0]  old_rank;
  logic [RANK_W-1:0]  new_rank;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RANK_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  hll_div_req_t       div_req;
  logic               div_done;
  logic [EST_W-1:0]   div_quot;
  logic               out_free;

  // leading-zero count plus one; the sentinel bit keeps the word nonzero
  function automatic logic [RANK_W-1:0] rank_of(input logic [HASH_W-1:0] w);
    logic [RANK_W-1:0] r;
    r = RANK_W'(HASH_W);
    for (int i = 0; i < HASH_W; i++) begin
      if (w[i]) begin
        r = RANK_W'(HASH_W - i);
      end
    end
    return r;
  endfunction

  assign p_eff = (prec_q < PREC_W'(PREC_MIN)) ? PREC_W'(PREC_MIN) :
                 (prec_q > PREC_W'(MAX_INDEX_BITS)) ? PREC_W'(MAX_INDEX_BITS) : prec_q;
  assign m_regs = CNT_W'(1) << p_eff;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign add_acc     = in_acc && (in_data_i.kind == KIND_ADD);
  assign est_acc     = in_acc && (in_data_i.kind == KIND_ESTIMATE);

  assign add_idx   = IDX_W'(in_data_i.hash_value >> (6'd32 - {2'b00, p_eff}));
  assign rank_word = (in_data_i.hash_value << p_eff) | (HASH_W'(1) << (p_eff - 1'b1));
  assign add_rank  = rank_of(rank_word);

  assign issuing    = (state_q == ST_SWEEP) && (cnt_q < m_regs);
  assign sweep_done = (state_q == ST_SWEEP) && !issuing && !rv_q;

  // forward the entry written at the edge that also latched this read
  assign old_rank = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_val_q : rdata;
  assign new_rank = (s1_rank_q > old_rank) ? s1_rank_q : old_rank;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_idx_q;
    ram_wdata = new_rank;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IDX_W-1:0];
      ram_wdata = '0;
    end else if (s1_valid_q) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = add_acc || issuing;
  assign ram_raddr = issuing ? cnt_q[IDX_W-1:0] : add_idx;

  hll_ram #(
    .WIDTH(RANK_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  assign div_req.start = sweep_done;
  assign div_req.num   = NUM_W'(alpha_q) << ({2'b00, p_eff, 1'b0} + 7'd24);
  assign div_req.den   = sum_q;

  hll_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    prec_d      = prec_q;
    alpha_d     = alpha_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    zeros_d     = zeros_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRECISION: prec_d  = cfg_data_i[PREC_W-1:0];
        CFG_ALPHA:     alpha_d = cfg_data_i[ALPHA_W-1:0];
        default:       ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q == ST_SWEEP && rv_q) begin
      sum_d = sum_q + (SUM_W'(1) << (6'd32 - {1'b0, rdata}));
      if (rdata == '0) begin
        zeros_d = zeros_q + 1'b1;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (est_acc) begin
          state_d = ST_SWEEP;
          cnt_d   = '0;
          sum_d   = '0;
          zeros_d = '0;
        end
      end
      ST_SWEEP: begin
        if (issuing) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (sweep_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d.raw_estimate   = div_quot;
          out_data_d.zero_registers = zeros_q;
          state_d                   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      prec_q      <= PREC_W'(12);
      alpha_q     <= ALPHA_W'(47259);
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prec_q      <= prec_d;
      alpha_q     <= alpha_d;
      cnt_q       <= cnt_d;
      rv_q        <= issuing;
      s1_valid_q  <= add_acc;
      fwd_valid_q <= s1_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    zeros_q    <= zeros_d;
    s1_idx_q   <= add_idx;
    s1_rank_q  <= add_rank;
    fwd_idx_q  <= s1_idx_q;
    fwd_val_q  <= new_rank;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
